// ===== sv/twe_pkg.sv =====
`timescale 1ns / 1ps

package twe_pkg;

  localparam int ConnIdW        = 6;
  localparam int SlotW          = 8;
  localparam int SizeW          = SlotW + 1;
  localparam int IdSpace        = 64;
  localparam int MaxSlots       = 256;
  localparam int NumConnDefault = 64;

  localparam logic [SlotW-1:0] TimeoutReset = SlotW'(3);

  typedef enum logic [1:0] {
    ReqAdd    = 2'd0,
    ReqDelete = 2'd1,
    ReqAdjust = 2'd2,
    ReqTick   = 2'd3
  } req_type_e;

  // Command from the request side into the wheel store
  typedef struct packed {
    logic               place;
    logic               drop;
    logic               tick;
    logic [ConnIdW-1:0] id;
    logic [SlotW-1:0]   slot;
    logic [SlotW-1:0]   cur;
  } twe_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } twe_stat_t;

endpackage

// ===== sv/timing_wheel_expiry.sv =====
// Channel   Direction  Handshake                Payload
// request   in         in_valid_i / in_stall_o   req_type_i, conn_id_i
// expiry    out        out_valid_o / out_stall_i expired_conn_o, expired_valid_o, last_o
// config    in         cfg_valid_i / cfg_ready_o timeout_ticks_i
//
// Add, delete and adjust leave no stall behind; the next transaction may follow at once.
// A tick stalls requests until its work is done: the scan reads the slot store once per id,
// drains the read pipeline and flushes the last result, then the remainder pass runs.
// After reset and after each config write the same remainder pass runs with
// requests stalled; activity bits clear at reset, so the slot store needs no clearing.
// A stalled expiry output holds the scan in place once a second hit is waiting.
`timescale 1ns / 1ps

module timing_wheel_expiry #(
  parameter int NUM_CONN = twe_pkg::NumConnDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [twe_pkg::ConnIdW-1:0] conn_id_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [twe_pkg::ConnIdW-1:0] expired_conn_o,
  output logic                        expired_valid_o,
  output logic                        last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [twe_pkg::SlotW-1:0]   timeout_ticks_i
);
  import twe_pkg::*;

  logic [SlotW-1:0] tt_q, tt_d;
  logic [SlotW-1:0] cur_q, cur_d;
  logic             start_q, start_d;
  logic [SizeW-1:0] wheel_size;
  logic [SizeW-1:0] cur_next;
  logic [SizeW-1:0] dividend;
  logic [SlotW-1:0] place_slot;
  logic             mod_busy;
  logic             in_accept;
  logic             id_ok;
  twe_cmd_t         cmd;
  twe_stat_t        stat;

  assign cfg_ready_o = 1'b1;

  assign wheel_size = (32'(tt_q) + 32'd1 > 32'(MaxSlots)) ? SizeW'(MaxSlots)
                                                          : {1'b0, tt_q} + SizeW'(1);
  assign cur_next   = ({1'b0, cur_q} + SizeW'(1) >= wheel_size) ? '0
                                                                : {1'b0, cur_q} + SizeW'(1);
  assign dividend   = {1'b0, cur_q} + {1'b0, tt_q};

  assign in_stall_o = stat.busy || start_q || mod_busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign id_ok      = (32'(conn_id_i) < NUM_CONN);

  always_comb begin
    cmd.place = in_accept && id_ok && (req_type_i == ReqAdd || req_type_i == ReqAdjust);
    cmd.drop  = in_accept && id_ok && (req_type_i == ReqDelete);
    cmd.tick  = in_accept && (req_type_i == ReqTick);
    cmd.id    = conn_id_i;
    cmd.slot  = place_slot;
    cmd.cur   = cur_q;
  end

  // Recompute the placement slot whenever the pointer or the timeout moves
  always_comb begin
    tt_d    = tt_q;
    cur_d   = cur_q;
    start_d = 1'b0;
    if (cfg_valid_i && cfg_ready_o) begin
      tt_d    = timeout_ticks_i;
      start_d = 1'b1;
    end
    if (stat.done) begin
      cur_d   = cur_next[SlotW-1:0];
      start_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tt_q    <= TimeoutReset;
      cur_q   <= '0;
      start_q <= 1'b1;
    end else begin
      tt_q    <= tt_d;
      cur_q   <= cur_d;
      start_q <= start_d;
    end
  end

  twe_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (dividend),
    .divisor_i  (wheel_size),
    .busy_o     (mod_busy),
    .rem_o      (place_slot)
  );

  twe_wheel_core #(
    .NUM_CONN (NUM_CONN)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_conn_o  (expired_conn_o),
    .out_hit_o   (expired_valid_o),
    .out_last_o  (last_o)
  );

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !expired_valid_o |-> last_o)
    else $error("empty expiry result without last");

  a_tick_blocks_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && req_type_i == ReqTick |=> in_stall_o)
    else $error("request taken right after a tick");

  a_pointer_in_wheel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |=> ({1'b0, cur_q} < wheel_size))
    else $error("slot pointer outside the wheel after a tick");

  a_place_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.place |-> !mod_busy && !start_q)
    else $error("placement while slot remainder is in flight");

endmodule

// ===== sv/twe_mod_unit.sv =====
`timescale 1ns / 1ps

module twe_mod_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [twe_pkg::SizeW-1:0] dividend_i,
  input  logic [twe_pkg::SizeW-1:0] divisor_i,
  output logic                      busy_o,
  output logic [twe_pkg::SlotW-1:0] rem_o
);
  import twe_pkg::*;

  localparam int CntW = $clog2(SizeW + 1);
  localparam logic [CntW-1:0] Steps = CntW'(SizeW);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SizeW-1:0] rem_q, rem_d;
  logic [SizeW-1:0] div_q, div_d;
  logic [SizeW-1:0] dsr_q, dsr_d;
  logic [SizeW:0]   trial;

  // Restoring remainder, one dividend bit per cycle
  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    div_d = div_q;
    dsr_d = dsr_q;
    trial = {rem_q, div_q[SizeW-1]};
    if (start_i) begin
      cnt_d = Steps;
      rem_d = '0;
      div_d = dividend_i;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, dsr_q}) begin
        trial = trial - {1'b0, dsr_q};
      end
      rem_d = trial[SizeW-1:0];
      div_d = {div_q[SizeW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = (cnt_q != '0);
  assign rem_o  = rem_q[SlotW-1:0];

endmodule

// ===== sv/twe_wheel_core.sv =====
`timescale 1ns / 1ps

module twe_wheel_core #(
  parameter int NUM_CONN = twe_pkg::NumConnDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  twe_pkg::twe_cmd_t           cmd_i,
  output twe_pkg::twe_stat_t          stat_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [twe_pkg::ConnIdW-1:0] out_conn_o,
  output logic                        out_hit_o,
  output logic                        out_last_o
);
  import twe_pkg::*;

  localparam int Depth = (NUM_CONN < IdSpace) ? NUM_CONN : IdSpace;
  localparam int IdxW  = $clog2(Depth);
  localparam logic [IdxW:0] DepthCnt = (IdxW+1)'(Depth);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [IdxW:0]      cnt_q, cnt_d;
  logic               s1_vld_q, s1_vld_d;
  logic [IdxW-1:0]    s1_idx_q, s1_idx_d;
  logic [SlotW-1:0]   scan_slot_q, scan_slot_d;
  logic               pend_vld_q, pend_vld_d;
  logic [IdxW-1:0]    pend_id_q, pend_id_d;
  logic [Depth-1:0]   active_q, active_d;
  logic               out_vld_q, out_vld_d;
  logic [ConnIdW-1:0] out_conn_q, out_conn_d;
  logic               out_hit_q, out_hit_d;
  logic               out_last_q, out_last_d;

  logic [SlotW-1:0]   mem [Depth];
  logic [SlotW-1:0]   rd_data_q;
  logic               mem_we, mem_re;
  logic [IdxW-1:0]    wr_idx, rd_idx;

  logic out_free, match, hold, done;

  assign wr_idx   = cmd_i.id[IdxW-1:0];
  assign rd_idx   = cnt_q[IdxW-1:0];
  assign out_free = !out_vld_q || !out_stall_i;
  assign match    = s1_vld_q && active_q[s1_idx_q] && (rd_data_q == scan_slot_q);
  // A second hit cannot move on while the held one has nowhere to go
  assign hold     = match && pend_vld_q && !out_free;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    s1_vld_d    = s1_vld_q;
    s1_idx_d    = s1_idx_q;
    scan_slot_d = scan_slot_q;
    pend_vld_d  = pend_vld_q;
    pend_id_d   = pend_id_q;
    active_d    = active_q;
    out_vld_d   = out_vld_q && out_stall_i;
    out_conn_d  = out_conn_q;
    out_hit_d   = out_hit_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    done        = 1'b0;

    case (state_q)
      StIdle: begin
        if (cmd_i.place) begin
          mem_we           = 1'b1;
          active_d[wr_idx] = 1'b1;
        end
        if (cmd_i.drop) begin
          active_d[wr_idx] = 1'b0;
        end
        if (cmd_i.tick) begin
          state_d     = StScan;
          cnt_d       = '0;
          s1_vld_d    = 1'b0;
          pend_vld_d  = 1'b0;
          scan_slot_d = cmd_i.cur;
        end
      end
      StScan: begin
        if (!hold) begin
          if (cnt_q != DepthCnt) begin
            mem_re   = 1'b1;
            s1_idx_d = rd_idx;
            s1_vld_d = 1'b1;
            cnt_d    = cnt_q + (IdxW+1)'(1);
          end else begin
            s1_vld_d = 1'b0;
          end
          if (match) begin
            active_d[s1_idx_q] = 1'b0;
            pend_vld_d         = 1'b1;
            pend_id_d          = s1_idx_q;
            // Release the previous hit; it is not the last one
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_conn_d = ConnIdW'(pend_id_q);
              out_hit_d  = 1'b1;
              out_last_d = 1'b0;
            end
          end
          if (cnt_q == DepthCnt && !s1_vld_q) begin
            state_d = StFlush;
          end
        end
      end
      StFlush: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_conn_d = pend_vld_q ? ConnIdW'(pend_id_q) : '0;
          out_hit_d  = pend_vld_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = StIdle;
          done       = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      s1_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      active_q   <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      s1_vld_q   <= s1_vld_d;
      pend_vld_q <= pend_vld_d;
      active_q   <= active_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q    <= s1_idx_d;
    scan_slot_q <= scan_slot_d;
    pend_id_q   <= pend_id_d;
    out_conn_q  <= out_conn_d;
    out_hit_q   <= out_hit_d;
    out_last_q  <= out_last_d;
  end

  // Slot store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_idx] <= cmd_i.slot;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_idx];
    end
  end

  assign stat_o.busy = (state_q != StIdle);
  assign stat_o.done = done;
  assign out_valid_o = out_vld_q;
  assign out_conn_o  = out_conn_q;
  assign out_hit_o   = out_hit_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== test/tb_timing_wheel_expiry.sv =====
`timescale 1ns / 1ps

module tb_timing_wheel_expiry;
  import twe_pkg::*;

  localparam int NumConn    = NumConnDefault;
  localparam int SettleCyc  = 100;
  localparam int HoldCyc    = 400;
  localparam int QuietLimit = 5000;
  localparam int ReportMax  = 10;

  typedef struct packed {
    logic [ConnIdW-1:0] conn;
    logic               hit;
    logic               fin;
  } expiry_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [1:0]         req_type_i      = ReqAdd;
  logic [ConnIdW-1:0] conn_id_i       = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [ConnIdW-1:0] expired_conn_o;
  logic               expired_valid_o;
  logic               last_o;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [SlotW-1:0]   timeout_ticks_i = TimeoutReset;

  // Wheel prediction state
  logic [SlotW-1:0] slot_of [NumConn];
  logic             armed   [NumConn];
  logic [SlotW-1:0] cur_slot;
  logic [SlotW-1:0] timeout;
  expiry_t          expiry_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int mismatch_cnt   = 0;
  int quiet_cycles   = 0;

  timing_wheel_expiry #(
    .NUM_CONN(NumConn)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .conn_id_i      (conn_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .expired_conn_o (expired_conn_o),
    .expired_valid_o(expired_valid_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .timeout_ticks_i(timeout_ticks_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned wheel_len();
    int unsigned n;
    n = int'(timeout) + 1;
    return (n > MaxSlots) ? MaxSlots : n;
  endfunction

  function automatic void flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= ReportMax) $display("%0t: %s", $time, msg);
  endfunction

  // Update the wheel for one accepted request and queue the expiries it causes
  function automatic void apply_request(req_type_e rt, logic [ConnIdW-1:0] id);
    int unsigned len;
    int unsigned nxt;
    expiry_t     hits[$];
    expiry_t     e;
    len = wheel_len();
    if (rt != ReqTick && int'(id) >= NumConn) return;
    case (rt)
      ReqAdd, ReqAdjust: begin
        slot_of[id] = SlotW'((int'(cur_slot) + int'(timeout)) % len);
        armed[id]   = 1'b1;
      end
      ReqDelete: begin
        armed[id] = 1'b0;
      end
      default: begin
        for (int i = 0; i < NumConn && i < IdSpace; i++) begin
          if (armed[i] && slot_of[i] == cur_slot) begin
            armed[i] = 1'b0;
            e.conn   = ConnIdW'(i);
            e.hit    = 1'b1;
            e.fin    = 1'b0;
            hits.push_back(e);
          end
        end
        if (hits.size() == 0) begin
          e.conn = '0;
          e.hit  = 1'b0;
          e.fin  = 1'b1;
          hits.push_back(e);
        end else begin
          hits[hits.size()-1].fin = 1'b1;
        end
        foreach (hits[k]) expiry_q.push_back(hits[k]);
        nxt      = int'(cur_slot) + 1;
        cur_slot = (nxt >= len) ? '0 : SlotW'(nxt);
      end
    endcase
  endfunction

  task automatic send_req(req_type_e rt, logic [ConnIdW-1:0] id);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    conn_id_i  <= id;
    do @(posedge clk_i); while (in_stall_o);
    apply_request(rt, id);
  endtask

  task automatic drain_wheel();
    in_valid_i <= 1'b0;
    while (expiry_q.size() != 0) @(posedge clk_i);
    // let a trailing tick finish its remainder pass
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [SlotW-1:0] val);
    cfg_valid_i     <= 1'b1;
    timeout_ticks_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    timeout = val;
  endtask

  task automatic test_directed_ops();
    send_req(ReqAdd, 6'd0);
    send_req(ReqAdd, 6'd63);
    send_req(ReqAdjust, 6'd42);   // inactive adjust acts as add
    send_req(ReqDelete, 6'd21);   // inactive delete is a no-op
    send_req(ReqAdd, 6'd21);
    send_req(ReqDelete, 6'd21);
    send_req(ReqTick, 6'd63);
    send_req(ReqAdd, 6'd0);       // reschedule an active connection
    repeat (4) send_req(ReqTick, 6'd0);
  endtask

  task automatic test_timeout_limits();
    drain_wheel();
    write_timeout(8'd0);          // one-slot wheel, placement in the current slot
    send_req(ReqAdd, 6'd10);
    send_req(ReqAdd, 6'd3);
    send_req(ReqTick, 6'd0);
    send_req(ReqTick, 6'd0);
    drain_wheel();
    write_timeout(8'hFF);
    repeat (4) send_req(ReqTick, 6'd0);
    send_req(ReqAdd, 6'd20);
    drain_wheel();
    // shrink the wheel below the pointer and strand the entry
    write_timeout(8'd1);
    send_req(ReqTick, 6'd0);
    send_req(ReqTick, 6'd0);
    send_req(ReqAdjust, 6'd20);
    send_req(ReqTick, 6'd0);
    send_req(ReqTick, 6'd0);
  endtask

  task automatic test_random_traffic(int sidle, int rstall, int n_items,
                                     logic [SlotW-1:0] tmo);
    int               pick;
    req_type_e        rt;
    logic [ConnIdW-1:0] id;
    drain_wheel();
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    write_timeout(tmo);
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2) drain_wheel();
      pick = $urandom_range(0, 99);
      id   = ConnIdW'($urandom_range(0, NumConn - 1));
      if (pick < 34)      rt = ReqAdd;
      else if (pick < 48) rt = ReqAdjust;
      else if (pick < 60) rt = ReqDelete;
      else                rt = ReqTick;
      send_req(rt, id);
    end
  endtask

  task automatic test_backpressure();
    drain_wheel();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_timeout(8'd1);
    hold_req = 1'b1;
    repeat (20) send_req(ReqAdd, ConnIdW'($urandom_range(0, NumConn - 1)));
    repeat (6) send_req(ReqTick, ConnIdW'($urandom_range(0, NumConn - 1)));
    drain_wheel();
  endtask

  // Expiry sink: random stalls plus an occasional long hold-off
  initial begin : expiry_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCyc;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_expiry
    expiry_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expiry_q.size() == 0) begin
        flag_error($sformatf("unexpected expiry conn=%0d valid=%0b last=%0b",
                             expired_conn_o, expired_valid_o, last_o));
      end else begin
        want = expiry_q.pop_front();
        if (expired_conn_o !== want.conn || expired_valid_o !== want.hit ||
            last_o !== want.fin) begin
          flag_error($sformatf({"expiry mismatch: expected conn=%0d valid=%0b last=%0b,",
                                " got conn=%0d valid=%0b last=%0b"},
                               want.conn, want.hit, want.fin,
                               expired_conn_o, expired_valid_o, last_o));
        end
      end
    end
  end

  // Abort when no transaction moves on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_timing_wheel_expiry: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NumConn; i++) begin
      slot_of[i] = '0;
      armed[i]   = 1'b0;
    end
    cur_slot = '0;
    timeout  = TimeoutReset;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ops();
    test_timeout_limits();
    test_random_traffic(22, 84, 143, 8'd2);
    test_random_traffic(84, 22, 143, SlotW'($urandom_range(1, 6)));
    test_backpressure();
    test_random_traffic(0, 0, 143, 8'd5);
    drain_wheel();

    if (mismatch_cnt == 0 && expiry_q.size() == 0) begin
      $display("tb_timing_wheel_expiry: clean");
    end else begin
      $display("tb_timing_wheel_expiry: errors");
    end
    $finish;
  end

endmodule
